[rtl/dli_pkg.sv]
// ----------------------------------------------------------------------------
// dli_pkg - shared types and constants for the door latch interlock PD drive
// Register layout, reset values, fixed latch damping and force limit and pipeline word types.
// ----------------------------------------------------------------------------
`default_nettype none

package dli_pkg;

  localparam int ANGLE_W = 16;
  localparam int ERR_W   = 17;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 4;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_UNLOCK_THR  = 4'd0;
  localparam logic [IDX_W-1:0] CFG_SVC_ANGLE   = 4'd1;
  localparam logic [IDX_W-1:0] CFG_CLOSED_TOL  = 4'd2;
  localparam logic [IDX_W-1:0] CFG_LATCH_LIMIT = 4'd3;
  localparam logic [IDX_W-1:0] CFG_HINGE_GAIN  = 4'd4;
  localparam logic [IDX_W-1:0] CFG_HINGE_DAMP  = 4'd5;
  localparam logic [IDX_W-1:0] CFG_HINGE_FLIM  = 4'd6;
  localparam logic [IDX_W-1:0] CFG_LATCH_GAIN  = 4'd7;

  // reset values
  localparam logic [13:0] RST_UNLOCK_THR  = 14'd1434;
  localparam logic [13:0] RST_SVC_ANGLE   = 14'd2458;
  localparam logic [13:0] RST_CLOSED_TOL  = 14'd328;
  localparam logic [13:0] RST_LATCH_LIMIT = 14'd3217;
  localparam logic [15:0] RST_HINGE_GAIN  = 16'd10752;
  localparam logic [15:0] RST_HINGE_DAMP  = 16'd1792;
  localparam logic [14:0] RST_HINGE_FLIM  = 15'd7680;
  localparam logic [15:0] RST_LATCH_GAIN  = 16'd4096;

  // fixed latch damping 2.0 (Q8.8) and force limit 8.0 (Q7.8)
  localparam logic [15:0] LATCH_DAMP = 16'd512;
  localparam logic [14:0] LATCH_FLIM = 15'd2048;

  typedef struct packed {
    logic [13:0] unlock_thr;
    logic [13:0] svc_angle;
    logic [13:0] closed_tol;
    logic [13:0] latch_limit;
    logic [15:0] hinge_gain;
    logic [15:0] hinge_damp;
    logic [14:0] hinge_flim;
    logic [15:0] latch_gain;
  } cfg_t;

  typedef struct packed {
    logic                      pos_valid;
    logic signed [ANGLE_W-1:0] hinge_upper;
    logic signed [ANGLE_W-1:0] hinge_lower;
    logic signed [ANGLE_W-1:0] latch_vel;
    logic signed [ANGLE_W-1:0] hinge_vel;
    logic signed [ANGLE_W-1:0] latch_pos;
    logic signed [ANGLE_W-1:0] hinge_pos;
    logic signed [ANGLE_W-1:0] latch_tgt;
    logic signed [ANGLE_W-1:0] hinge_tgt;
  } in_t;

  typedef struct packed {
    logic                      pos_valid;
    logic                      unlocked;
    logic signed [ERR_W-1:0]   hinge_err;
    logic signed [ERR_W-1:0]   latch_err;
    logic signed [ANGLE_W-1:0] hinge_vel;
    logic signed [ANGLE_W-1:0] latch_vel;
  } err_t;

  typedef struct packed {
    logic pos_valid;
    logic unlocked;
  } flags_t;

  // magnitude of a 16-bit signed value, exact for the most negative code
  function automatic logic [ANGLE_W:0] mag16(input logic signed [ANGLE_W-1:0] v);
    logic signed [ANGLE_W:0] w;
    w = {v[ANGLE_W-1], v};
    return w[ANGLE_W] ? (-w) : w;
  endfunction

endpackage

`default_nettype wire

[rtl/dli_target.sv]
// ----------------------------------------------------------------------------
// dli_target - target clamps, latch interlock and position errors
// Combinational: latch clamp and service hold, hinge clamp and unlock gate.
// ----------------------------------------------------------------------------
`default_nettype none

module dli_target (
  input  dli_pkg::in_t  in_word,
  input  dli_pkg::cfg_t cfg,
  output dli_pkg::err_t err_word
);
  import dli_pkg::*;

  logic signed [ANGLE_W:0]   lt_ext;
  logic signed [ANGLE_W:0]   llim;
  logic signed [ANGLE_W:0]   lclamp;
  logic signed [ANGLE_W-1:0] l_eff;
  logic signed [ANGLE_W-1:0] h_eff;
  logic signed [ANGLE_W-1:0] svc;
  logic [ANGLE_W:0]          thr;
  logic [ANGLE_W:0]          lpos_mag;
  logic                      unlocked;
  logic                      hold;
  logic                      neg;

  always_comb begin
    thr      = {3'b000, cfg.unlock_thr};
    lpos_mag = mag16(in_word.latch_pos);
    unlocked = (lpos_mag >= thr);

    lt_ext = {in_word.latch_tgt[ANGLE_W-1], in_word.latch_tgt};
    llim   = {3'b000, cfg.latch_limit};
    lclamp = lt_ext;
    if (lclamp > llim) lclamp = llim;
    if (lclamp < -llim) lclamp = -llim;

    // lock request while the door stands open: hold at the service angle
    hold = (mag16(lclamp[ANGLE_W-1:0]) < thr) &&
           (mag16(in_word.hinge_pos) > {3'b000, cfg.closed_tol});
    neg  = (lpos_mag > thr) && in_word.latch_pos[ANGLE_W-1];
    svc  = {2'b00, cfg.svc_angle};
    if (hold) l_eff = neg ? -svc : svc;
    else l_eff = lclamp[ANGLE_W-1:0];

    if (in_word.hinge_tgt < in_word.hinge_lower) h_eff = in_word.hinge_lower;
    else if (in_word.hinge_tgt > in_word.hinge_upper) h_eff = in_word.hinge_upper;
    else h_eff = in_word.hinge_tgt;
    if (!unlocked) h_eff = '0;

    err_word.pos_valid = in_word.pos_valid;
    err_word.unlocked  = unlocked;
    err_word.latch_err = {l_eff[ANGLE_W-1], l_eff} -
                         {in_word.latch_pos[ANGLE_W-1], in_word.latch_pos};
    err_word.hinge_err = {h_eff[ANGLE_W-1], h_eff} -
                         {in_word.hinge_pos[ANGLE_W-1], in_word.hinge_pos};
    err_word.hinge_vel = in_word.hinge_vel;
    err_word.latch_vel = in_word.latch_vel;
  end

endmodule

`default_nettype wire

[rtl/dli_pd_lane.sv]
// ----------------------------------------------------------------------------
// dli_pd_lane - one PD force lane
// Registers gain*err and damping*vel, then truncates toward zero to Q.8,
// subtracts and saturates to +/- limit.
// ----------------------------------------------------------------------------
`default_nettype none

module dli_pd_lane (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic signed [dli_pkg::ERR_W-1:0]   err,
  input  wire logic signed [dli_pkg::ANGLE_W-1:0] vel,
  input  wire logic [15:0]                        gain,
  input  wire logic [15:0]                        damp,
  input  wire logic [14:0]                        limit,
  output logic signed [dli_pkg::ANGLE_W-1:0]      force_q8
);
  import dli_pkg::*;

  logic signed [33:0] p_r;
  logic signed [33:0] p_nxt;
  logic signed [32:0] d_r;
  logic signed [32:0] d_nxt;
  logic signed [33:0] p_adj;
  logic signed [32:0] d_adj;
  logic signed [21:0] p_q;
  logic signed [24:0] d_q;
  logic signed [25:0] f;
  logic signed [25:0] lim;
  logic signed [25:0] f_sat;

  assign p_nxt = $signed({1'b0, gain}) * err;
  assign d_nxt = $signed({1'b0, damp}) * vel;

  always_ff @(posedge clk) begin
    if (load) begin
      p_r <= p_nxt;
      d_r <= d_nxt;
    end
  end

  always_comb begin
    // bias negatives before the shift so the result rounds toward zero
    p_adj = p_r + $signed({22'd0, {12{p_r[33]}}});
    d_adj = d_r + $signed({25'd0, {8{d_r[32]}}});
    p_q   = p_adj[33:12];
    d_q   = d_adj[32:8];
    f     = {{4{p_q[21]}}, p_q} - {d_q[24], d_q};
    lim   = {11'd0, limit};
    f_sat = f;
    if (f_sat > lim) f_sat = lim;
    if (f_sat < -lim) f_sat = -lim;
    force_q8 = f_sat[ANGLE_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/door_latch_interlock_pd_drive_unit.sv]
// Throughput: one word per cycle; four registered stages (input, error,
// product, output) each advance when the next one is empty or moving.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// configuration registers with their default values.
// ----------------------------------------------------------------------------
// door_latch_interlock_pd_drive_unit - door latch interlock PD drive
// Clamps hinge and latch targets with the latch interlock and produces two
// saturated PD forces per control tick.
// ----------------------------------------------------------------------------
`default_nettype none

module door_latch_interlock_pd_drive_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // hinge_target, latch_target, hinge_position, latch_position,
  // hinge_velocity, latch_velocity, hinge_lower, hinge_upper
  input  wire logic [127:0]              in_tdata,
  // positions_valid
  input  wire logic [0:0]                in_tuser,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // hinge_force, latch_force
  output logic [31:0]                    out_tdata,
  // drive_valid, latch_unlocked
  output logic [1:0]                     out_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  input  wire logic                      cfg_we,
  input  wire logic [dli_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [dli_pkg::CFG_W-1:0] cfg_wdata
);
  import dli_pkg::*;

  cfg_t   cfg_r;
  in_t    in_r;
  err_t   err_r;
  err_t   err_nxt;
  flags_t flags_r;
  logic   v1_r, v2_r, v3_r, v4_r;
  logic   adv1, adv2, adv3, adv4;
  logic signed [ANGLE_W-1:0] hinge_force;
  logic signed [ANGLE_W-1:0] latch_force;
  logic [31:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unlock_thr  <= RST_UNLOCK_THR;
      cfg_r.svc_angle   <= RST_SVC_ANGLE;
      cfg_r.closed_tol  <= RST_CLOSED_TOL;
      cfg_r.latch_limit <= RST_LATCH_LIMIT;
      cfg_r.hinge_gain  <= RST_HINGE_GAIN;
      cfg_r.hinge_damp  <= RST_HINGE_DAMP;
      cfg_r.hinge_flim  <= RST_HINGE_FLIM;
      cfg_r.latch_gain  <= RST_LATCH_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNLOCK_THR:  cfg_r.unlock_thr  <= cfg_wdata[13:0];
        CFG_SVC_ANGLE:   cfg_r.svc_angle   <= cfg_wdata[13:0];
        CFG_CLOSED_TOL:  cfg_r.closed_tol  <= cfg_wdata[13:0];
        CFG_LATCH_LIMIT: cfg_r.latch_limit <= cfg_wdata[13:0];
        CFG_HINGE_GAIN:  cfg_r.hinge_gain  <= cfg_wdata[15:0];
        CFG_HINGE_DAMP:  cfg_r.hinge_damp  <= cfg_wdata[15:0];
        CFG_HINGE_FLIM:  cfg_r.hinge_flim  <= cfg_wdata[14:0];
        CFG_LATCH_GAIN:  cfg_r.latch_gain  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage moves when it is empty or its successor moves
  assign adv4      = !v4_r || out_tready;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) in_r <= {in_tuser[0], in_tdata};
    if (adv2) err_r <= err_nxt;
    if (adv3) flags_r <= '{pos_valid: err_r.pos_valid, unlocked: err_r.unlocked};
    if (adv4) begin
      if (flags_r.pos_valid) begin
        out_tdata_r <= {latch_force, hinge_force};
        out_tuser_r <= {flags_r.unlocked, 1'b1};
      end else begin
        out_tdata_r <= '0;
        out_tuser_r <= '0;
      end
    end
  end

  dli_target u_target (
    .in_word  (in_r),
    .cfg      (cfg_r),
    .err_word (err_nxt)
  );

  dli_pd_lane u_hinge (
    .clk      (clk),
    .load     (adv3),
    .err      (err_r.hinge_err),
    .vel      (err_r.hinge_vel),
    .gain     (cfg_r.hinge_gain),
    .damp     (cfg_r.hinge_damp),
    .limit    (cfg_r.hinge_flim),
    .force_q8 (hinge_force)
  );

  dli_pd_lane u_latch (
    .clk      (clk),
    .load     (adv3),
    .err      (err_r.latch_err),
    .vel      (err_r.latch_vel),
    .gain     (cfg_r.latch_gain),
    .damp     (LATCH_DAMP),
    .limit    (LATCH_FLIM),
    .force_q8 (latch_force)
  );

  assign out_tvalid = v4_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

[rtl/dli_checker.sv]
// ----------------------------------------------------------------------------
// dli_checker - port-level checks for the door latch interlock PD drive
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dli_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // no drive: both forces and the unlock flag are zero
  a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 32'd0 && !out_tuser[1])
    else $error("nonzero result without drive_valid");

  // latch force stays inside the fixed +/-8.0 limit
  a_latch_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[31:16]) <= 16'sd2048 &&
                   $signed(out_tdata[31:16]) >= -16'sd2048)
    else $error("latch force beyond limit");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

endmodule

bind door_latch_interlock_pd_drive_unit dli_checker u_dli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

[test/door_latch_interlock_pd_drive_unit_check.sv]
// ----------------------------------------------------------------------------
// door_latch_interlock_pd_drive_unit_check - drive word checker
// Watches the input, output and register ports of the PD drive unit, keeps
// its own copy of the registers, computes the expected hinge and latch forces
// for every accepted input word and compares them in order with the output.
// ----------------------------------------------------------------------------
`default_nettype none

module door_latch_interlock_pd_drive_unit_check (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [127:0]              in_tdata,
  input  wire logic [0:0]                in_tuser,
  input  wire logic                      in_tvalid,
  input  wire logic                      in_tready,
  input  wire logic [31:0]               out_tdata,
  input  wire logic [1:0]                out_tuser,
  input  wire logic                      out_tvalid,
  input  wire logic                      out_tready,
  input  wire logic                      cfg_we,
  input  wire logic [dli_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [dli_pkg::CFG_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             drives_pending
);

  import dli_pkg::*;

  typedef struct {
    logic signed [15:0] hinge_force;
    logic signed [15:0] latch_force;
    logic               drive_valid;
    logic               latch_unlocked;
  } drive_result_t;

  drive_result_t expected_drives[$];
  cfg_t          regs_q;

  function automatic int mag_of(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // gain*err is Q.20 and damping*vel is Q.16; both truncate toward zero to Q.8
  function automatic logic [15:0] saturated_pd(input int tgt, input int pos, input int vel,
                                               input int gain, input int damp, input int lim);
    longint f;
    f = (longint'(gain) * longint'(tgt - pos)) / 4096 - (longint'(damp) * longint'(vel)) / 256;
    if (f > lim) f = lim;
    if (f < -lim) f = -lim;
    return f[15:0];
  endfunction

  function automatic drive_result_t predict_drive(input in_t w, input cfg_t r);
    drive_result_t d;
    int thr, llim, l_tgt, h_tgt, h_pos, l_pos, h_lo, h_hi, svc, tol;
    int h_vel, l_vel, hg, hd, hl, lg, ld, ll;
    logic unl, neg;
    d.hinge_force    = '0;
    d.latch_force    = '0;
    d.drive_valid    = 1'b0;
    d.latch_unlocked = 1'b0;
    if (!w.pos_valid) return d;
    thr   = r.unlock_thr;
    llim  = r.latch_limit;
    svc   = r.svc_angle;
    tol   = r.closed_tol;
    hg    = r.hinge_gain;
    hd    = r.hinge_damp;
    hl    = r.hinge_flim;
    lg    = r.latch_gain;
    ld    = LATCH_DAMP;
    ll    = LATCH_FLIM;
    l_tgt = w.latch_tgt;
    h_tgt = w.hinge_tgt;
    h_pos = w.hinge_pos;
    l_pos = w.latch_pos;
    h_vel = w.hinge_vel;
    l_vel = w.latch_vel;
    h_lo  = w.hinge_lower;
    h_hi  = w.hinge_upper;

    if (l_tgt > llim) l_tgt = llim;
    if (l_tgt < -llim) l_tgt = -llim;
    // interlock: a locking target while the hinge is open holds the service angle
    if (mag_of(l_tgt) < thr && mag_of(h_pos) > tol) begin
      neg   = mag_of(l_pos) > thr && l_pos < 0;
      l_tgt = neg ? -svc : svc;
    end
    unl = mag_of(l_pos) >= thr;

    // lower limit is checked first: with crossed limits a target below it takes the lower limit, any other the upper
    if (h_tgt < h_lo) h_tgt = h_lo;
    else if (h_tgt > h_hi) h_tgt = h_hi;
    if (!unl) h_tgt = 0;

    d.latch_force    = saturated_pd(l_tgt, l_pos, l_vel, lg, ld, ll);
    d.hinge_force    = saturated_pd(h_tgt, h_pos, h_vel, hg, hd, hl);
    d.drive_valid    = 1'b1;
    d.latch_unlocked = unl;
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  initial begin
    mismatches     = 0;
    drives_pending = 0;
  end

  always @(posedge clk) begin
    drive_result_t exp_d;
    if (!rst_n) begin
      regs_q.unlock_thr  = RST_UNLOCK_THR;
      regs_q.svc_angle   = RST_SVC_ANGLE;
      regs_q.closed_tol  = RST_CLOSED_TOL;
      regs_q.latch_limit = RST_LATCH_LIMIT;
      regs_q.hinge_gain  = RST_HINGE_GAIN;
      regs_q.hinge_damp  = RST_HINGE_DAMP;
      regs_q.hinge_flim  = RST_HINGE_FLIM;
      regs_q.latch_gain  = RST_LATCH_GAIN;
      expected_drives.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_drives.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h/%b", out_tdata, out_tuser));
        end else begin
          exp_d = expected_drives.pop_front();
          if (out_tdata[15:0] !== exp_d.hinge_force)
            report_mismatch($sformatf("hinge_force expected %0d got %0d",
                                      exp_d.hinge_force, $signed(out_tdata[15:0])));
          if (out_tdata[31:16] !== exp_d.latch_force)
            report_mismatch($sformatf("latch_force expected %0d got %0d",
                                      exp_d.latch_force, $signed(out_tdata[31:16])));
          if (out_tuser[0] !== exp_d.drive_valid)
            report_mismatch($sformatf("drive_valid expected %b got %b",
                                      exp_d.drive_valid, out_tuser[0]));
          if (out_tuser[1] !== exp_d.latch_unlocked)
            report_mismatch($sformatf("latch_unlocked expected %b got %b",
                                      exp_d.latch_unlocked, out_tuser[1]));
        end
      end
      if (in_tvalid && in_tready)
        expected_drives.push_back(predict_drive(in_t'({in_tuser, in_tdata}), regs_q));
      if (cfg_we) begin
        case (cfg_index)
          CFG_UNLOCK_THR:  regs_q.unlock_thr  = cfg_wdata[13:0];
          CFG_SVC_ANGLE:   regs_q.svc_angle   = cfg_wdata[13:0];
          CFG_CLOSED_TOL:  regs_q.closed_tol  = cfg_wdata[13:0];
          CFG_LATCH_LIMIT: regs_q.latch_limit = cfg_wdata[13:0];
          CFG_HINGE_GAIN:  regs_q.hinge_gain  = cfg_wdata;
          CFG_HINGE_DAMP:  regs_q.hinge_damp  = cfg_wdata;
          CFG_HINGE_FLIM:  regs_q.hinge_flim  = cfg_wdata[14:0];
          CFG_LATCH_GAIN:  regs_q.latch_gain  = cfg_wdata;
          default: ;
        endcase
      end
    end
    drives_pending = expected_drives.size();
  end

endmodule

`default_nettype wire

[test/door_latch_interlock_pd_drive_unit_test.sv]
// ----------------------------------------------------------------------------
// door_latch_interlock_pd_drive_unit_test - PD drive unit testbench
// Runs directed interlock and clamp cases at the default registers, then
// random control ticks shaped around the current thresholds under several
// register settings (defaults, all maximum, all zero, over-wide writes,
// random). Both stream sides idle at random; the checker predicts and
// compares every drive word.
// ----------------------------------------------------------------------------
`default_nettype none

module door_latch_interlock_pd_drive_unit_test;

  import dli_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 150;
  localparam logic [IDX_W-1:0] CFG_UNUSED_LO = 4'd8;
  localparam logic [IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

  logic               clk;
  logic               rst_n;
  logic [127:0]       in_tdata;
  logic [0:0]         in_tuser;
  logic               in_tvalid;
  logic               in_tready;
  logic [31:0]        out_tdata;
  logic [1:0]         out_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  int                 mismatches;
  int                 drives_pending;

  int                 thr_now, tol_now, llim_now;
  int                 words_sent;
  bit                 send_calm;

  door_latch_interlock_pd_drive_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  door_latch_interlock_pd_drive_unit_check i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .drives_pending (drives_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_t mk_word(input int ht, input int lt, input int hp, input int lp,
                                  input int hv, input int lv, input int lo, input int hi,
                                  input bit pv);
    in_t w;
    w.hinge_tgt   = ht[15:0];
    w.latch_tgt   = lt[15:0];
    w.hinge_pos   = hp[15:0];
    w.latch_pos   = lp[15:0];
    w.hinge_vel   = hv[15:0];
    w.latch_vel   = lv[15:0];
    w.hinge_lower = lo[15:0];
    w.hinge_upper = hi[15:0];
    w.pos_valid   = pv;
    return w;
  endfunction

  // value around +/-c, or anything at all
  function automatic int near(input int c);
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return c + int'($urandom_range(0, 6)) - 3;
      2:       return -c + int'($urandom_range(0, 6)) - 3;
      3:       return int'($urandom_range(0, 2 * c + 64)) - c - 32;
      default: return $urandom_range(0, 1) ? 0 : ($urandom_range(0, 1) ? 32767 : -32768);
    endcase
  endfunction

  function automatic in_t random_word();
    int lo, hi, t;
    lo = $urandom_range(0, 3) == 0 ? int'($urandom) : -int'($urandom_range(0, 13000));
    hi = $urandom_range(0, 3) == 0 ? int'($urandom) : int'($urandom_range(0, 13000));
    if ($urandom_range(0, 7) == 0) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    return mk_word($urandom_range(0, 1) ? int'($urandom) : int'($urandom_range(0, 28000)) - 14000,
                   near($urandom_range(0, 1) ? thr_now : llim_now),
                   near(tol_now),
                   near(thr_now),
                   $urandom_range(0, 1) ? int'($urandom) : int'($urandom_range(0, 4000)) - 2000,
                   $urandom_range(0, 1) ? int'($urandom) : int'($urandom_range(0, 4000)) - 2000,
                   lo, hi, $urandom_range(0, 9) != 0);
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input in_t w);
    int gap;
    if (words_sent % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    {in_tuser, in_tdata} <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_word(random_word());
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (drives_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic cfg_put(input logic [IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(negedge clk);
  endtask

  task automatic load_settings(input int thr, input int svc, input int tol, input int llim,
                               input int hg, input int hd, input int hf, input int lg);
    cfg_put(CFG_UNLOCK_THR, thr);
    cfg_put(CFG_SVC_ANGLE, svc);
    cfg_put(CFG_CLOSED_TOL, tol);
    cfg_put(CFG_LATCH_LIMIT, llim);
    cfg_put(CFG_HINGE_GAIN, hg);
    cfg_put(CFG_HINGE_DAMP, hd);
    cfg_put(CFG_HINGE_FLIM, hf);
    cfg_put(CFG_LATCH_GAIN, lg);
    thr_now  = thr & 16'h3fff;
    tol_now  = tol & 16'h3fff;
    llim_now = llim & 16'h3fff;
  endtask

  // output side: random stalls, calm stretches, one long hold-off
  initial begin : sink
    int gap;
    int taken;
    bit calm;
    out_tready = 1'b0;
    taken      = 0;
    calm       = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (taken % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 12);
      if (taken == 200) gap = HOLD_CYCLES;  // pipeline fills, input must stall
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    words_sent = 0;
    send_calm  = 1'b0;
    thr_now    = RST_UNLOCK_THR;
    tol_now    = RST_CLOSED_TOL;
    llim_now   = RST_LATCH_LIMIT;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default registers: thr 1434, tolerance 328, latch limit 3217
    send_word(mk_word(-1, -1, -1, -1, -1, -1, -1, -1, 1'b0));
    send_word(mk_word(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_word(mk_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1));
    send_word(mk_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1));
    send_word(mk_word(0, 20000, 0, 2000, 100, -100, -4096, 4096, 1'b1));
    send_word(mk_word(0, -20000, 0, -2000, -100, 100, -4096, 4096, 1'b1));
    // hinge open or at the tolerance, latch targets locking or at the threshold
    send_word(mk_word(0, 100, 329, -1435, 0, 0, -4096, 4096, 1'b1));
    send_word(mk_word(0, 100, 329, -1434, 0, 0, -4096, 4096, 1'b1));
    send_word(mk_word(0, -100, -329, 1500, 0, 0, -4096, 4096, 1'b1));
    send_word(mk_word(0, 100, 328, -2000, 0, 0, -4096, 4096, 1'b1));
    send_word(mk_word(0, 1434, 2000, -2000, 0, 0, -4096, 4096, 1'b1));
    send_word(mk_word(0, -1433, 2000, -2000, 0, 0, -4096, 4096, 1'b1));
    // hinge target clamps, normal and crossed limits
    send_word(mk_word(-8000, 0, 0, 2000, 0, 0, -4096, 4096, 1'b1));
    send_word(mk_word(8000, 0, 0, -2000, 0, 0, -4096, 4096, 1'b1));
    send_word(mk_word(-8000, 0, 0, 2000, 0, 0, 4096, -4096, 1'b1));
    send_word(mk_word(5000, 0, 0, 2000, 0, 0, 4096, -4096, 1'b1));
    send_word(mk_word(0, 0, 0, 2000, 0, 0, 4096, -4096, 1'b1));
    // latch locked forces the hinge target to zero; extremes and unlock threshold edges
    send_word(mk_word(8000, 0, 100, 100, 50, 50, -4096, 4096, 1'b1));
    send_word(mk_word(32767, 3217, -32768, -32768, -32768, 32767, -32768, 32767, 1'b1));
    send_word(mk_word(-32768, -3217, 32767, 32767, 32767, -32768, -32768, 32767, 1'b1));
    send_word(mk_word(100, 200, 300, 1434, 256, -256, -1000, 1000, 1'b1));
    send_word(mk_word(0, 0, 0, 1433, 0, 0, 0, 0, 1'b1));
    send_word(mk_word(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_random(375);

    wait_drained();
    load_settings(12867, 12867, 12867, 12867, 65535, 65535, 32767, 65535);
    cfg_we <= 1'b0;
    send_random(200);

    wait_drained();
    load_settings(0, 0, 0, 0, 0, 0, 0, 0);
    cfg_we <= 1'b0;
    send_random(200);

    // bits above each register's width are dropped; unknown indexes ignored
    wait_drained();
    load_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    cfg_put(CFG_UNUSED_LO, 16'h0000);
    cfg_put(CFG_UNUSED_HI, 16'h1234);
    cfg_we <= 1'b0;
    send_random(150);

    repeat (3) begin
      wait_drained();
      load_settings($urandom_range(0, 12867), $urandom_range(0, 12867),
                    $urandom_range(0, 12867), $urandom_range(0, 12867),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 32767), $urandom_range(0, 65535));
      cfg_we <= 1'b0;
      send_random(200);
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/dli_pkg.sv
rtl/dli_target.sv
rtl/dli_pd_lane.sv
rtl/door_latch_interlock_pd_drive_unit.sv
rtl/dli_checker.sv
test/door_latch_interlock_pd_drive_unit_check.sv
test/door_latch_interlock_pd_drive_unit_test.sv
